@@ src/xcrc_pkg.sv @@
// Shared constants, item types and the CRC step function for the XMODEM-CRC receiver.
package xcrc_pkg;

  // Block layout.
  localparam int BLOCK_BYTES  = 133;
  localparam int HEADER_BYTES = 3;
  localparam int PAGE_BYTES   = 128;
  localparam int PAGE_WORDS   = PAGE_BYTES / 2;
  localparam int PAGE_AW      = $clog2(PAGE_BYTES);
  localparam int WORD_AW      = $clog2(PAGE_WORDS);
  localparam int ADDR_W       = 17;

  // Queue between the front and the back.
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // Input kind codes.
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_TICK  = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_RETRY   = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_LIMIT   = 2'd2;

  // Session status codes.
  localparam logic [1:0] STAT_RUN    = 2'd0;
  localparam logic [1:0] STAT_OK     = 2'd1;
  localparam logic [1:0] STAT_LOWMEM = 2'd2;
  localparam logic [1:0] STAT_NODATA = 2'd3;

  // Protocol characters.
  localparam logic [7:0] CH_C   = 8'h43;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_EOT = 8'h04;

  localparam logic [15:0]       CRC_POLY = 16'h1021;
  localparam logic [ADDR_W-1:0] PTR_MAX  = 17'h1FFFF;

  // Reset values of the configuration registers.
  localparam logic [7:0]        RETRY_RESET   = 8'd3;
  localparam logic [7:0]        TIMEOUT_RESET = 8'd10;
  localparam logic [ADDR_W-1:0] LIMIT_RESET   = 17'd28672;

  // One job from the front: a single result, or a burst of program words.
  typedef struct packed {
    logic              burst;
    logic              tx_valid;
    logic [7:0]        tx_byte;
    logic [7:0]        blocks;
    logic [1:0]        status;
    logic [ADDR_W-1:0] base;
  } job_t;

  // One byte of CRC-16, MSB first.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ src/xmodem_crc_receiver_unit.sv @@
// Top level of the XMODEM-CRC receiver: front, job queue, page buffer and back.
//
// Usage: each input item is a start event, a one-second tick or one received byte
// (in_kind, in_rx_byte). Every item yields one result item, except the final byte of
// a block with a good CRC, which yields 64 program words with ACK on the last one.
// Results carry the reply byte, the program word and address, the block count and the
// session status; out_last marks the final result of an item.
// Configuration (retry interval, data timeout, flash limit) goes through the cfg_
// channel, always ready; the user writes it only while the block is idle (not enforced).
// Order: an accepted item passes through the job queue to the registered output; the
// first word of a burst follows once the job is popped and the page is read, then one
// word per cycle while out_ready is high.
// Throughput: one item per cycle while results are taken; input is held off after the
// closing byte of a good block until the back has read out all 64 words, and when the
// two-entry job queue fills.
// Reset: the session goes idle, the configuration registers take their defaults and
// the queue empties; no clearing pass is needed.
// A stalled receiver fills the output register and then the queue, after which
// in_ready drops until results are taken again.
module xmodem_crc_receiver_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_kind,
  input  logic [7:0]                  in_rx_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_tx_valid,
  output logic [7:0]                  out_tx_byte,
  output logic                        out_prog_valid,
  output logic [xcrc_pkg::ADDR_W-1:0] out_prog_address,
  output logic [15:0]                 out_prog_word,
  output logic [7:0]                  out_blocks_received,
  output logic [1:0]                  out_session_status,
  output logic                        out_last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [xcrc_pkg::ADDR_W-1:0] cfg_data
);

  logic                         q_ready;
  logic                         q_push;
  xcrc_pkg::job_t               q_job;
  logic                         q_pop;
  logic                         q_valid;
  xcrc_pkg::job_t               q_head;
  logic                         pb_wr_en;
  logic [xcrc_pkg::WORD_AW-1:0] pb_wr_addr;
  logic [15:0]                  pb_wr_data;
  logic [xcrc_pkg::WORD_AW-1:0] pb_rd_addr;
  logic [15:0]                  pb_rd_data;
  logic                         burst_done;

  // Front: session state, CRC and page writes.
  xcrc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_kind    (in_kind),
    .in_rx_byte (in_rx_byte),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_ready    (q_ready),
    .q_push     (q_push),
    .q_job      (q_job),
    .pb_wr_en   (pb_wr_en),
    .pb_wr_addr (pb_wr_addr),
    .pb_wr_data (pb_wr_data),
    .burst_done (burst_done)
  );

  // Job queue.
  xcrc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_job),
    .ready     (q_ready),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  // Page buffer, one 16-bit word per pair of block bytes.
  xcrc_ram #(
    .WIDTH (16),
    .DEPTH (xcrc_pkg::PAGE_WORDS)
  ) u_page_ram (
    .clk     (clk),
    .wr_en   (pb_wr_en),
    .wr_addr (pb_wr_addr),
    .wr_data (pb_wr_data),
    .rd_addr (pb_rd_addr),
    .rd_data (pb_rd_data)
  );

  // Back: result items and word bursts.
  xcrc_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_head              (q_head),
    .q_pop               (q_pop),
    .pb_rd_addr          (pb_rd_addr),
    .pb_rd_data          (pb_rd_data),
    .burst_done          (burst_done),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_tx_valid        (out_tx_valid),
    .out_tx_byte         (out_tx_byte),
    .out_prog_valid      (out_prog_valid),
    .out_prog_address    (out_prog_address),
    .out_prog_word       (out_prog_word),
    .out_blocks_received (out_blocks_received),
    .out_session_status  (out_session_status),
    .out_last            (out_last)
  );

endmodule

@@ src/xcrc_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module xcrc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/xcrc_queue.sv @@
// Short job queue between the front and the back of the receiver.
module xcrc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  xcrc_pkg::job_t push_data,
  output logic           ready,
  input  logic           pop,
  output logic           valid,
  output xcrc_pkg::job_t head
);

  xcrc_pkg::job_t                   mem_r [xcrc_pkg::Q_DEPTH];
  logic [xcrc_pkg::Q_AW-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [xcrc_pkg::Q_AW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [xcrc_pkg::Q_AW:0]          count_r, count_nxt;

  assign ready = (count_r != (xcrc_pkg::Q_AW + 1)'(xcrc_pkg::Q_DEPTH));
  assign valid = (count_r != '0);
  assign head  = mem_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ src/xcrc_front.sv @@
// Front of the receiver: accepts items, runs the session state and CRC, queues jobs.
module xcrc_front (
  input  logic                        clk,
  input  logic                        rst_n,
  // Input channel.
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_kind,
  input  logic [7:0]                  in_rx_byte,
  // Configuration channel.
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [xcrc_pkg::ADDR_W-1:0] cfg_data,
  // Job queue.
  input  logic                        q_ready,
  output logic                        q_push,
  output xcrc_pkg::job_t              q_job,
  // Page buffer write port.
  output logic                        pb_wr_en,
  output logic [xcrc_pkg::WORD_AW-1:0] pb_wr_addr,
  output logic [15:0]                 pb_wr_data,
  // Back reports the end of a word burst.
  input  logic                        burst_done
);

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_WAIT = 4'b0010,
    PH_RECV = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  phase_t                      phase_r, phase_nxt;
  logic [7:0]                  byte_cnt_r, byte_cnt_nxt;
  logic [7:0]                  sec_r, sec_nxt;
  logic [15:0]                 crc_r, crc_nxt;
  logic [7:0]                  crch_r, crch_nxt;
  logic [7:0]                  blk_r, blk_nxt;
  logic [xcrc_pkg::ADDR_W-1:0] fp_r, fp_nxt;
  logic [1:0]                  status_r, status_nxt;
  logic [7:0]                  lo_byte_r, lo_byte_nxt;
  logic                        busy_r, busy_nxt;
  logic [7:0]                  retry_r, retry_nxt;
  logic [7:0]                  timeout_r, timeout_nxt;
  logic [xcrc_pkg::ADDR_W-1:0] limit_r, limit_nxt;

  logic                        accept;
  logic                        do_take;
  logic [7:0]                  sec_inc;
  logic [15:0]                 crc_base;
  logic [7:0]                  page_off;
  logic [xcrc_pkg::PAGE_AW-1:0] page_idx;
  logic [xcrc_pkg::ADDR_W:0]   fp_sum;

  // The front holds off while a burst of program words still reads the page buffer.
  assign in_ready  = q_ready && !busy_r;
  assign accept    = in_valid && in_ready;
  assign q_push    = accept;
  assign cfg_ready = 1'b1;

  assign sec_inc  = (sec_r == 8'hFF) ? sec_r : sec_r + 8'd1;
  assign crc_base = (byte_cnt_r == 8'd0) ? 16'h0000 : crc_r;
  assign page_off = byte_cnt_r - 8'(xcrc_pkg::HEADER_BYTES);
  assign page_idx = page_off[xcrc_pkg::PAGE_AW-1:0];
  assign fp_sum   = {1'b0, fp_r} + (xcrc_pkg::ADDR_W + 1)'(xcrc_pkg::PAGE_BYTES);

  assign pb_wr_addr = page_idx[xcrc_pkg::PAGE_AW-1:1];
  assign pb_wr_data = {in_rx_byte, lo_byte_r};

  // Session state and job build.
  always_comb begin
    phase_nxt    = phase_r;
    byte_cnt_nxt = byte_cnt_r;
    sec_nxt      = sec_r;
    crc_nxt      = crc_r;
    crch_nxt     = crch_r;
    blk_nxt      = blk_r;
    fp_nxt       = fp_r;
    status_nxt   = status_r;
    lo_byte_nxt  = lo_byte_r;
    pb_wr_en     = 1'b0;
    do_take      = 1'b0;
    q_job        = '0;

    if (accept) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (in_kind == xcrc_pkg::KIND_START) begin
            phase_nxt      = PH_WAIT;
            sec_nxt        = 8'd0;
            byte_cnt_nxt   = 8'd0;
            crc_nxt        = 16'h0000;
            q_job.tx_valid = 1'b1;
            q_job.tx_byte  = xcrc_pkg::CH_C;
          end
        end
        PH_WAIT: begin
          if (in_kind == xcrc_pkg::KIND_TICK) begin
            sec_nxt = sec_inc;
            if (sec_inc >= retry_r) begin
              sec_nxt        = 8'd0;
              q_job.tx_valid = 1'b1;
              q_job.tx_byte  = xcrc_pkg::CH_C;
            end
          end else if (in_kind == xcrc_pkg::KIND_BYTE) begin
            phase_nxt = PH_RECV;
            do_take   = 1'b1;
          end
        end
        PH_RECV: begin
          if (in_kind == xcrc_pkg::KIND_TICK) begin
            sec_nxt = sec_inc;
            if (sec_inc >= timeout_r) begin
              phase_nxt  = PH_DONE;
              status_nxt = xcrc_pkg::STAT_NODATA;
            end
          end else if (in_kind == xcrc_pkg::KIND_BYTE) begin
            do_take = 1'b1;
          end
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase

      // Handling of one received byte.
      if (do_take) begin
        if (sec_r >= timeout_r) begin
          phase_nxt  = PH_DONE;
          status_nxt = xcrc_pkg::STAT_NODATA;
        end else begin
          crc_nxt = crc_base;
          if (byte_cnt_r >= 8'(xcrc_pkg::HEADER_BYTES) &&
              byte_cnt_r < 8'(xcrc_pkg::HEADER_BYTES + xcrc_pkg::PAGE_BYTES)) begin
            // Even bytes wait in a register, odd bytes complete a word write.
            if (!page_idx[0]) begin
              lo_byte_nxt = in_rx_byte;
            end else begin
              pb_wr_en = 1'b1;
            end
            crc_nxt = xcrc_pkg::crc_feed(crc_base, in_rx_byte);
          end else if (byte_cnt_r == 8'(xcrc_pkg::HEADER_BYTES + xcrc_pkg::PAGE_BYTES)) begin
            crch_nxt = in_rx_byte;
          end
          byte_cnt_nxt = byte_cnt_r + 8'd1;

          if (byte_cnt_r == 8'd0 && in_rx_byte == xcrc_pkg::CH_EOT) begin
            // End of transfer.
            phase_nxt      = PH_DONE;
            status_nxt     = xcrc_pkg::STAT_OK;
            q_job.tx_valid = 1'b1;
            q_job.tx_byte  = xcrc_pkg::CH_ACK;
          end else if (byte_cnt_r < 8'(xcrc_pkg::BLOCK_BYTES - 1)) begin
            // Block still incomplete.
          end else if (fp_r >= limit_r) begin
            phase_nxt  = PH_DONE;
            status_nxt = xcrc_pkg::STAT_LOWMEM;
          end else begin
            blk_nxt      = blk_r + 8'd1;
            byte_cnt_nxt = 8'd0;
            if (crch_r == crc_r[15:8] && in_rx_byte == crc_r[7:0]) begin
              // Good block: hand the page to the back as a burst.
              q_job.burst = 1'b1;
              q_job.base  = fp_r;
              fp_nxt      = fp_sum[xcrc_pkg::ADDR_W] ? xcrc_pkg::PTR_MAX
                                                     : fp_sum[xcrc_pkg::ADDR_W-1:0];
              sec_nxt     = 8'd0;
            end else begin
              q_job.tx_valid = 1'b1;
              q_job.tx_byte  = xcrc_pkg::CH_NAK;
            end
          end
        end
      end
    end

    q_job.blocks = blk_nxt;
    q_job.status = status_nxt;
  end

  // Burst tracking.
  always_comb begin
    busy_nxt = busy_r;
    if (burst_done) begin
      busy_nxt = 1'b0;
    end else if (accept && q_job.burst) begin
      busy_nxt = 1'b1;
    end
  end

  // Configuration register writes.
  always_comb begin
    retry_nxt   = retry_r;
    timeout_nxt = timeout_r;
    limit_nxt   = limit_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        xcrc_pkg::CFG_RETRY:   retry_nxt   = cfg_data[7:0];
        xcrc_pkg::CFG_TIMEOUT: timeout_nxt = cfg_data[7:0];
        xcrc_pkg::CFG_LIMIT:   limit_nxt   = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      byte_cnt_r <= '0;
      sec_r      <= '0;
      crc_r      <= '0;
      crch_r     <= '0;
      blk_r      <= '0;
      fp_r       <= '0;
      status_r   <= xcrc_pkg::STAT_RUN;
      busy_r     <= 1'b0;
      retry_r    <= xcrc_pkg::RETRY_RESET;
      timeout_r  <= xcrc_pkg::TIMEOUT_RESET;
      limit_r    <= xcrc_pkg::LIMIT_RESET;
    end else begin
      phase_r    <= phase_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      sec_r      <= sec_nxt;
      crc_r      <= crc_nxt;
      crch_r     <= crch_nxt;
      blk_r      <= blk_nxt;
      fp_r       <= fp_nxt;
      status_r   <= status_nxt;
      busy_r     <= busy_nxt;
      retry_r    <= retry_nxt;
      timeout_r  <= timeout_nxt;
      limit_r    <= limit_nxt;
    end
  end

  // The pending low byte is payload.
  always_ff @(posedge clk) begin
    lo_byte_r <= lo_byte_nxt;
  end

  // A queued burst blocks new items until the back has read the page.
  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !in_ready)
    else $error("front accepts an item during a word burst");

  a_burst_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && q_job.burst) |=> busy_r)
    else $error("burst job queued without marking the front busy");

  a_page_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    pb_wr_en |-> (phase_r == PH_RECV || phase_r == PH_WAIT))
    else $error("page buffer written outside of reception");

endmodule

@@ src/xcrc_back.sv @@
// Back of the receiver: turns queued jobs into result items, reading page words for bursts.
module xcrc_back (
  input  logic                         clk,
  input  logic                         rst_n,
  // Job queue.
  input  logic                         q_valid,
  input  xcrc_pkg::job_t               q_head,
  output logic                         q_pop,
  // Page buffer read port.
  output logic [xcrc_pkg::WORD_AW-1:0] pb_rd_addr,
  input  logic [15:0]                  pb_rd_data,
  output logic                         burst_done,
  // Result channel.
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_tx_valid,
  output logic [7:0]                   out_tx_byte,
  output logic                         out_prog_valid,
  output logic [xcrc_pkg::ADDR_W-1:0]  out_prog_address,
  output logic [15:0]                  out_prog_word,
  output logic [7:0]                   out_blocks_received,
  output logic [1:0]                   out_session_status,
  output logic                         out_last
);

  typedef enum logic [1:0] {
    BK_IDLE = 2'b01,
    BK_READ = 2'b10
  } back_state_t;

  back_state_t                  state_r, state_nxt;
  xcrc_pkg::job_t               job_r, job_nxt;
  logic [xcrc_pkg::WORD_AW-1:0] idx_r, idx_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic                         out_tx_valid_r, out_tx_valid_nxt;
  logic [7:0]                   out_tx_byte_r, out_tx_byte_nxt;
  logic                         out_prog_valid_r, out_prog_valid_nxt;
  logic [xcrc_pkg::ADDR_W-1:0]  out_addr_r, out_addr_nxt;
  logic [15:0]                  out_word_r, out_word_nxt;
  logic [7:0]                   out_blocks_r, out_blocks_nxt;
  logic [1:0]                   out_status_r, out_status_nxt;
  logic                         out_last_r, out_last_nxt;

  logic                         out_free;
  logic                         word_end;

  assign out_free = !out_valid_r || out_ready;
  assign word_end = (idx_r == xcrc_pkg::WORD_AW'(xcrc_pkg::PAGE_WORDS - 1));

  // The page is read ahead, addressed by the next word index.
  assign pb_rd_addr = idx_nxt;

  always_comb begin
    state_nxt          = state_r;
    job_nxt            = job_r;
    idx_nxt            = idx_r;
    q_pop              = 1'b0;
    burst_done         = 1'b0;
    out_valid_nxt      = out_valid_r && !out_ready;
    out_tx_valid_nxt   = out_tx_valid_r;
    out_tx_byte_nxt    = out_tx_byte_r;
    out_prog_valid_nxt = out_prog_valid_r;
    out_addr_nxt       = out_addr_r;
    out_word_nxt       = out_word_r;
    out_blocks_nxt     = out_blocks_r;
    out_status_nxt     = out_status_r;
    out_last_nxt       = out_last_r;

    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          if (q_head.burst) begin
            // Take the burst and start reading word zero.
            job_nxt   = q_head;
            q_pop     = 1'b1;
            idx_nxt   = '0;
            state_nxt = BK_READ;
          end else if (out_free) begin
            q_pop              = 1'b1;
            out_valid_nxt      = 1'b1;
            out_tx_valid_nxt   = q_head.tx_valid;
            out_tx_byte_nxt    = q_head.tx_byte;
            out_prog_valid_nxt = 1'b0;
            out_addr_nxt       = '0;
            out_word_nxt       = '0;
            out_blocks_nxt     = q_head.blocks;
            out_status_nxt     = q_head.status;
            out_last_nxt       = 1'b1;
          end
        end
      end
      BK_READ: begin
        if (out_free) begin
          // One program word per item; ACK rides on the final word.
          out_valid_nxt      = 1'b1;
          out_tx_valid_nxt   = word_end;
          out_tx_byte_nxt    = word_end ? xcrc_pkg::CH_ACK : 8'h00;
          out_prog_valid_nxt = 1'b1;
          out_addr_nxt       = job_r.base + xcrc_pkg::ADDR_W'({idx_r, 1'b0});
          out_word_nxt       = pb_rd_data;
          out_blocks_nxt     = job_r.blocks;
          out_status_nxt     = job_r.status;
          out_last_nxt       = word_end;
          if (word_end) begin
            burst_done = 1'b1;
            state_nxt  = BK_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    job_r            <= job_nxt;
    out_tx_valid_r   <= out_tx_valid_nxt;
    out_tx_byte_r    <= out_tx_byte_nxt;
    out_prog_valid_r <= out_prog_valid_nxt;
    out_addr_r       <= out_addr_nxt;
    out_word_r       <= out_word_nxt;
    out_blocks_r     <= out_blocks_nxt;
    out_status_r     <= out_status_nxt;
    out_last_r       <= out_last_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_tx_valid        = out_tx_valid_r;
  assign out_tx_byte         = out_tx_byte_r;
  assign out_prog_valid      = out_prog_valid_r;
  assign out_prog_address    = out_addr_r;
  assign out_prog_word       = out_word_r;
  assign out_blocks_received = out_blocks_r;
  assign out_session_status  = out_status_r;
  assign out_last            = out_last_r;

  // The final word of a burst returns the back to idle.
  a_burst_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_READ && out_free && word_end) |=> state_r == BK_IDLE)
    else $error("burst did not end after its final word");

  a_word_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_prog_valid_r && out_tx_valid_r) |-> out_tx_byte_r == xcrc_pkg::CH_ACK)
    else $error("program word carries a reply other than ACK");

  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("job popped from an empty queue");

endmodule
